### hw/rtl/iec_pkg.sv
// Shared types, codes and key table for the input event confirm unit.
package iec_pkg;

	localparam int unsigned CODE_W = 5;
	localparam int unsigned PIN_W  = 8;

	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [2:0] {
		CMD_PORT_A = 3'd0,
		CMD_PORT_B = 3'd1,
		CMD_ESTOP  = 3'd2,
		CMD_START  = 3'd3,
		CMD_QUIET  = 3'd4
	} cmd_t;

	localparam code_t EV_KEY_LAST   = 5'd7;
	localparam code_t EV_THERM_PRS  = 5'd8;
	localparam code_t EV_THERM_REL  = 5'd9;
	localparam code_t EV_STOP_PRS   = 5'd10;
	localparam code_t EV_STOP_REL   = 5'd11;
	localparam code_t EV_SPEED_BASE = 5'd12;
	localparam code_t EV_SPEED_LAST = 5'd19;
	localparam code_t EV_ESTOP_PRS  = 5'd20;
	localparam code_t EV_ESTOP_REL  = 5'd21;
	localparam code_t EV_START_PRS  = 5'd22;
	localparam code_t EV_START_REL  = 5'd23;
	localparam code_t EV_NONE       = 5'd31;

	localparam int unsigned THERM_BIT = 6;
	localparam int unsigned STOP_BIT  = 5;
	localparam logic [PIN_W-1:0] SPEED_MASK = 8'h1C;

	typedef struct packed {
		logic  upd;
		code_t code;
	} cls_t;

	function automatic logic [PIN_W-1:0] key_code(input logic [2:0] idx);
		logic [PIN_W-1:0] k;
		unique case (idx)
			3'd0: k = 8'h2E;
			3'd1: k = 8'h1D;
			3'd2: k = 8'h2B;
			3'd3: k = 8'h1B;
			3'd4: k = 8'h27;
			3'd5: k = 8'h1E;
			3'd6: k = 8'h2D;
			3'd7: k = 8'h17;
			default: k = 8'h17;
		endcase
		return k;
	endfunction

	function automatic code_t speed_code(input logic [PIN_W-1:0] pa);
		logic [PIN_W-1:0] inv;
		inv = (~pa) & SPEED_MASK;
		return EV_SPEED_BASE + {2'b00, inv[4:2]};
	endfunction

endpackage

### hw/rtl/iec_classify.sv
// Notice decoder: picks the new pending candidate for one notice word.
module iec_classify (
	input  logic [2:0]                cmd,
	input  logic [iec_pkg::PIN_W-1:0] change_flags,
	input  logic [iec_pkg::PIN_W-1:0] port_a_pins,
	input  logic [iec_pkg::PIN_W-1:0] port_b_pins,
	input  logic                      estop_level,
	input  logic                      start_level,
	output iec_pkg::cls_t             cls
);
	import iec_pkg::*;

	logic        key_hit;
	logic [2:0]  key_idx;

	always_comb begin
		key_hit = 1'b0;
		key_idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (port_b_pins == key_code(3'(i))) begin
				key_hit = 1'b1;
				key_idx = 3'(i);
			end
		end
	end

	always_comb begin
		cls.upd  = 1'b0;
		cls.code = EV_NONE;
		unique case (cmd)
			CMD_PORT_A: begin
				priority if (change_flags[THERM_BIT]) begin
					cls.upd  = 1'b1;
					cls.code = port_a_pins[THERM_BIT] ? EV_THERM_REL : EV_THERM_PRS;
				end else if ((change_flags & SPEED_MASK) != '0) begin
					cls.upd  = 1'b1;
					cls.code = speed_code(port_a_pins);
				end else if (change_flags[STOP_BIT]) begin
					cls.upd  = 1'b1;
					cls.code = port_a_pins[STOP_BIT] ? EV_STOP_REL : EV_STOP_PRS;
				end
			end
			CMD_PORT_B: begin
				cls.upd  = key_hit;
				cls.code = {2'b00, key_idx};
			end
			CMD_ESTOP: begin
				cls.upd  = 1'b1;
				cls.code = estop_level ? EV_ESTOP_PRS : EV_ESTOP_REL;
			end
			CMD_START: begin
				cls.upd  = 1'b1;
				cls.code = start_level ? EV_START_REL : EV_START_PRS;
			end
			default: begin
				cls.upd  = 1'b0;
				cls.code = EV_NONE;
			end
		endcase
	end

endmodule

### hw/rtl/iec_confirm.sv
// Level check: tells whether the pending candidate still holds.
module iec_confirm (
	input  iec_pkg::code_t            pending,
	input  logic [iec_pkg::PIN_W-1:0] port_a_pins,
	input  logic [iec_pkg::PIN_W-1:0] port_b_pins,
	input  logic                      estop_level,
	input  logic                      start_level,
	output logic                      hold
);
	import iec_pkg::*;

	always_comb begin
		priority if (pending <= EV_KEY_LAST)
			hold = (port_b_pins == key_code(pending[2:0]));
		else if (pending == EV_THERM_PRS)
			hold = !port_a_pins[THERM_BIT];
		else if (pending == EV_THERM_REL)
			hold = port_a_pins[THERM_BIT];
		else if (pending == EV_STOP_PRS)
			hold = !port_a_pins[STOP_BIT];
		else if (pending == EV_STOP_REL)
			hold = port_a_pins[STOP_BIT];
		else if (pending >= EV_SPEED_BASE && pending <= EV_SPEED_LAST)
			hold = (speed_code(port_a_pins) == pending);
		else if (pending == EV_ESTOP_PRS)
			hold = estop_level;
		else if (pending == EV_ESTOP_REL)
			hold = !estop_level;
		else if (pending == EV_START_PRS)
			hold = !start_level;
		else if (pending == EV_START_REL)
			hold = start_level;
		else
			hold = 1'b0;
	end

endmodule

### hw/rtl/input_event_confirm_unit.sv
// Top level: input register, pending candidate, result register.
// Each word waits in the input register; its result is loaded into the result register.
// Throughput: one word per cycle unless the output stalls; pending_q updates on advance.
// Ready follows the output register: a new word enters whenever the result slot drains.
// Reset clears the input and result valid flags and sets the pending candidate to none.
module input_event_confirm_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// change_flags[7:0], port_a_pins[15:8], port_b_pins[23:16],
	// estop_level[24], start_level[25], zero[31:26]
	input  logic [31:0] s_axis_tdata,
	// cmd[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// event_code[4:0], beep[5], zero[7:6]
	output logic [7:0]  m_axis_tdata
);
	import iec_pkg::*;

	logic             valid_s1;
	logic [2:0]       cmd_s1;
	logic [PIN_W-1:0] flags_s1;
	logic [PIN_W-1:0] pa_s1;
	logic [PIN_W-1:0] pb_s1;
	logic             estop_s1;
	logic             start_s1;

	code_t            pending_q;
	logic             out_valid_q;
	code_t            out_code_q;
	logic             out_beep_q;

	cls_t             cls;
	logic             hold;
	logic             advance;
	logic             quiet;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign quiet         = (cmd_s1 == CMD_QUIET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			flags_s1 <= s_axis_tdata[7:0];
			pa_s1    <= s_axis_tdata[15:8];
			pb_s1    <= s_axis_tdata[23:16];
			estop_s1 <= s_axis_tdata[24];
			start_s1 <= s_axis_tdata[25];
			cmd_s1   <= s_axis_tuser;
		end
	end

	iec_classify u_classify (
		.cmd          (cmd_s1),
		.change_flags (flags_s1),
		.port_a_pins  (pa_s1),
		.port_b_pins  (pb_s1),
		.estop_level  (estop_s1),
		.start_level  (start_s1),
		.cls          (cls)
	);

	iec_confirm u_confirm (
		.pending     (pending_q),
		.port_a_pins (pa_s1),
		.port_b_pins (pb_s1),
		.estop_level (estop_s1),
		.start_level (start_s1),
		.hold        (hold)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= EV_NONE;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && quiet && hold;
			if (valid_s1) begin
				if (quiet)
					pending_q <= EV_NONE;
				else if (cls.upd)
					pending_q <= cls.code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_code_q <= pending_q;
			out_beep_q <= (pending_q <= EV_KEY_LAST);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_beep_q, out_code_q};

	a_quiet_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && quiet && advance) |=> (pending_q == EV_NONE))
		else $error("pending candidate not cleared by quiet word");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_code_q <= EV_START_REL))
		else $error("result carries an undefined event code");

	a_beep_keys: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_beep_q == (out_code_q <= EV_KEY_LAST)))
		else $error("beep flag disagrees with event code");

endmodule
